### hw/rtl/circular_deque_store_defines.svh
// ----------------------------------------------------------------------------
// circular_deque_store_defines.svh
// assertion macros for the deque store checker
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_STORE_DEFINES_SVH
`define CIRCULAR_DEQUE_STORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// codes and types shared by the deque store modules
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned ElemWidth = 32;

  // request codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_READ_ALL   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic signed [ElemWidth-1:0] elem_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_ROTATE
  } cell_op_t;

endpackage

### hw/rtl/circular_deque_store.sv
// ----------------------------------------------------------------------------
// circular_deque_store
// bounded double-ended queue of 32-bit elements held in a chain of cells
// ----------------------------------------------------------------------------
// results: push, pop and error results appear in the cycle after the item is taken
// flow: push and pop items are taken back to back while the result sink is ready
// read all: the item moves the block to the read state, which then sends the front
//   element and rotates the chain by one cell, one element per cycle while the sink is ready
// reset: synchronous, clears the fill count, cell occupancy and output valid;
//   cell elements keep whatever they held
module circular_deque_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // request item
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dq_pkg::ElemWidth-1:0] s_tdata,   // [31:0] value
  input  logic [2:0]                   s_tuser,   // [2:0] func
  // result item
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dq_pkg::ElemWidth-1:0] m_tdata,   // [31:0] elem
  output logic [1:0]                   m_tuser,   // [1:0] status
  output logic                         m_tlast    // last result of the item
);
  import dq_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t        state;
  logic [FW-1:0] fill;       // number of held elements
  logic [FW-1:0] rd_cnt;     // elements already sent during read all

  elem_t         cell_data  [DEPTH];
  logic          cell_valid [DEPTH];
  cell_op_t      cell_op;
  elem_t         tail_data;

  logic accept;
  logic out_free;
  logic empty;
  logic full;
  logic rd_last;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign empty    = (fill == '0);
  assign full     = (fill == FW'(DEPTH));
  assign rd_last  = (rd_cnt == fill - FW'(1));

  // the chain: cell 0 is the front, valid cells form a run from cell 0;
  // the front end takes the pushed value, the back end sees an empty neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t l_data;
    logic  l_valid;
    elem_t r_data;
    logic  r_valid;

    if (i == 0) begin : g_front
      assign l_data  = elem_t'(s_tdata);
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .push_value  (elem_t'(s_tdata)),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .head_data   (cell_data[0]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  // back element: the one valid cell whose right neighbor is empty
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        tail_data = tail_data | cell_data[i];
      end
    end
  end

  // operation broadcast along the chain
  always_comb begin
    cell_op = CELL_HOLD;
    if (accept) begin
      unique case (s_tuser)
        FN_PUSH_FRONT: if (!full)  cell_op = CELL_PUSH_FRONT;
        FN_PUSH_BACK:  if (!full)  cell_op = CELL_PUSH_BACK;
        FN_POP_FRONT:  if (!empty) cell_op = CELL_POP_FRONT;
        FN_POP_BACK:   if (!empty) cell_op = CELL_POP_BACK;
        default:       cell_op = CELL_HOLD;
      endcase
    end else if (state == S_READ && out_free) begin
      // one full turn of the ring brings the order back to where it was
      cell_op = CELL_ROTATE;
    end
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      fill     <= '0;
      rd_cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            m_tlast <= 1'b1;
            unique case (s_tuser) inside
              FN_PUSH_FRONT, FN_PUSH_BACK: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                if (full) begin
                  m_tuser <= ST_FULL;
                end else begin
                  m_tuser <= ST_OK;
                  fill    <= fill + FW'(1);
                end
              end
              FN_POP_FRONT, FN_POP_BACK: begin
                m_tvalid <= 1'b1;
                if (empty) begin
                  m_tuser <= ST_EMPTY;
                  m_tdata <= '0;
                end else begin
                  m_tuser <= ST_OK;
                  fill    <= fill - FW'(1);
                  m_tdata <= (s_tuser == FN_POP_FRONT) ? cell_data[0] : tail_data;
                end
              end
              FN_READ_ALL: begin
                m_tdata <= '0;
                if (empty) begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= ST_EMPTY;
                end else begin
                  // elements follow from the read state
                  m_tvalid <= 1'b0;
                  m_tuser  <= ST_OK;
                  rd_cnt   <= '0;
                  state    <= S_READ;
                end
              end
              default: begin
                // unused codes give a plain ok item
                m_tvalid <= 1'b1;
                m_tuser  <= ST_OK;
                m_tdata  <= '0;
              end
            endcase
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        S_READ: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_OK;
            m_tdata  <= cell_data[0];
            m_tlast  <= rd_last;
            rd_cnt   <= rd_cnt + FW'(1);
            if (rd_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// one slot of the deque chain, element plus occupancy bit
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic             clk,
  input  logic             rst,
  input  dq_pkg::cell_op_t op,
  input  dq_pkg::elem_t    push_value,
  input  dq_pkg::elem_t    left_data,
  input  logic             left_valid,
  input  dq_pkg::elem_t    right_data,
  input  logic             right_valid,
  input  dq_pkg::elem_t    head_data,
  output dq_pkg::elem_t    data,
  output logic             valid
);
  import dq_pkg::*;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        CELL_PUSH_FRONT: valid <= left_valid;
        CELL_PUSH_BACK:  if (!valid && left_valid) valid <= 1'b1;
        CELL_POP_FRONT:  valid <= right_valid;
        CELL_POP_BACK:   if (valid && !right_valid) valid <= 1'b0;
        default:         valid <= valid;
      endcase
    end
  end

  // element, no reset
  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH_FRONT: data <= left_data;
      CELL_PUSH_BACK:  if (!valid && left_valid) data <= push_value;
      CELL_POP_FRONT:  data <= right_data;
      CELL_ROTATE:     if (valid) data <= right_valid ? right_data : head_data;
      default:         data <= data;
    endcase
  end

endmodule

### hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// port-level checks for the deque store, bound to the top level
// ----------------------------------------------------------------------------
`include "circular_deque_store_defines.svh"

module dq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [2:0]                   s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [dq_pkg::ElemWidth-1:0] m_tdata,
  input logic [1:0]                   m_tuser,
  input logic                         m_tlast
);
  import dq_pkg::*;

  // a stalled result keeps its payload
  `DQ_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // an error result carries no element and ends its item
  `DQ_ASSERT_NOW(a_err_item, clk, rst, m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY), m_tdata == '0 && m_tlast, "error result with element or without last")

  // every request but read all is answered in the next cycle by a single item
  `DQ_ASSERT_NEXT(a_single, clk, rst, s_tvalid && s_tready && s_tuser != FN_READ_ALL, m_tvalid && m_tlast, "single result missing")

  // no status code beyond the defined three
  `DQ_ASSERT_NOW(a_status, clk, rst, m_tvalid, m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_EMPTY, "undefined status")

endmodule

bind circular_deque_store dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the deque store against a ring-buffer predictor: empty and full
// errors, both ends of the deque, read-out of every element and unused codes,
// then random traffic under several patterns of source idling and sink stalls
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int HEAD_W       = $clog2(DEPTH);
  localparam int DRAIN_CYCLES = DEPTH + 4;
  // request codes the block must ignore
  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    elem_t      elem;
    logic       last;
  } result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ElemWidth-1:0] s_tdata  = '0;
  logic [2:0]           s_tuser  = FN_PUSH_FRONT;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ElemWidth-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  // predictor state: ring of slots, front index and element count
  elem_t                    ring_slots [DEPTH];
  logic [HEAD_W-1:0]        ring_head = '0;
  logic [HEAD_W:0]          ring_fill = '0;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      idle_pct       = 0;
  int      stall_pct      = 0;

  circular_deque_store #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic expect_result(input logic [1:0] status, input elem_t elem, input logic last);
    pending_results.push_back('{status: status, elem: elem, last: last});
  endtask

  // ring-buffer model of the deque, run once per accepted request item
  task automatic predict_deque(input logic [2:0] fn, input elem_t val);
    int pos;
    case (fn) inside
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (fn == FN_PUSH_FRONT) begin
            ring_head = HEAD_W'((int'(ring_head) + DEPTH - 1) % DEPTH);
            pos = int'(ring_head);
          end else begin
            pos = (int'(ring_head) + int'(ring_fill)) % DEPTH;
          end
          ring_slots[pos] = val;
          ring_fill = ring_fill + 1'b1;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (ring_fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (fn == FN_POP_FRONT) begin
            pos = int'(ring_head);
            ring_head = HEAD_W'((int'(ring_head) + 1) % DEPTH);
          end else begin
            pos = (int'(ring_head) + int'(ring_fill) - 1) % DEPTH;
          end
          ring_fill = ring_fill - 1'b1;
          expect_result(ST_OK, ring_slots[pos], 1'b1);
        end
      end
      FN_READ_ALL: begin
        if (ring_fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(ring_fill); i++) begin
            expect_result(ST_OK, ring_slots[(int'(ring_head) + i) % DEPTH],
                          i == int'(ring_fill) - 1);
          end
        end
      end
      default: expect_result(ST_OK, '0, 1'b1);
    endcase
  endtask

  // one request item: optional idle gap, then hold valid until taken
  task automatic send_item(input logic [2:0] fn, input elem_t val);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_deque(fn, val);
  endtask

  // source goes quiet until every expected result is back
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_result;
    result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t unexpected result: status %0d elem %0d last %0b",
               $time, m_tuser, $signed(m_tdata), m_tlast);
    end else begin
      want = pending_results.pop_front();
      if (m_tuser !== want.status) begin
        mismatch_count++;
        $display("%0t status: expected %0d actual %0d", $time, want.status, m_tuser);
      end
      if (m_tdata !== want.elem) begin
        mismatch_count++;
        $display("%0t elem: expected %0d actual %0d", $time, want.elem, $signed(m_tdata));
      end
      if (m_tlast !== want.last) begin
        mismatch_count++;
        $display("%0t last: expected %0b actual %0b", $time, want.last, m_tlast);
      end
    end
  endtask

  // sink: random stalls and result checking
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) check_result();
  end

  function automatic elem_t pick_value;
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // pops and read-outs of a store that holds nothing
  task automatic test_empty_store;
    send_item(FN_POP_FRONT, pick_value());
    send_item(FN_POP_BACK, pick_value());
    send_item(FN_READ_ALL, pick_value());
  endtask

  // fill from both ends, the first eight with extreme values, refuse two more, read it all
  task automatic test_full_store;
    elem_t edge_vals [4];
    edge_vals = '{32'sh8000_0000, 32'sh7fff_ffff, '0, -32'sd1};
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT,
                (i < 8) ? edge_vals[i % 4] : elem_t'($urandom));
    end
    send_item(FN_PUSH_FRONT, pick_value());
    send_item(FN_PUSH_BACK, pick_value());
    send_item(FN_READ_ALL, pick_value());
  endtask

  task automatic test_unused_codes;
    for (int code = FN_UNUSED_LO; code <= FN_UNUSED_HI; code++) begin
      send_item(code[2:0], pick_value());
    end
  endtask

  // random traffic that swings between filling and draining the store
  task automatic test_random_mix(input int n_items, input int src_idle, input int sink_stall);
    logic        filling;
    int          roll;
    logic [2:0]  fn;
    idle_pct  = src_idle;
    stall_pct = sink_stall;
    filling   = (ring_fill < DEPTH / 2);
    for (int n = 0; n < n_items; n++) begin
      if (ring_fill == DEPTH) filling = 1'b0;
      else if (ring_fill == 0) filling = 1'b1;
      else if ($urandom_range(99) < 5) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 5) fn = 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
      else if (roll < 15) fn = FN_READ_ALL;
      else if ($urandom_range(99) < (filling ? 80 : 20))
        fn = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      else
        fn = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
      send_item(fn, pick_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_full_store();
    test_unused_codes();
    wait_for_results();
    test_random_mix(34, 0, 0);
    wait_for_results();
    test_random_mix(34, 45, 0);
    wait_for_results();
    test_random_mix(34, 0, 45);
    wait_for_results();
    test_random_mix(34, 24, 24);
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
